// ===== sv/utf8g7_pkg.sv =====
// Shared types, constants and character tables for the UTF-8 to GSM 7-bit encoder.
package utf8g7_pkg;

    localparam int BYTE_W         = 8;
    localparam int CHAR_W         = 16;
    localparam int CODE_W         = 7;
    localparam int COUNT_W        = 10;
    localparam int MAX_TEXT_BYTES = 256;
    localparam int CODE_LIMIT     = (2 * MAX_TEXT_BYTES < 1023) ? 2 * MAX_TEXT_BYTES : 1023;
    localparam int MAIN_N         = 42;
    localparam int ESC_N          = 9;

    localparam logic [CODE_W-1:0] ESC_CODE  = 7'h1B;
    localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;

    localparam logic [CHAR_W-1:0] MAIN_UNI [MAIN_N] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9,
        16'h00EC, 16'h00F2, 16'h00E7, 16'h00D8, 16'h00F8, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0,
        16'h03A8, 16'h03A3, 16'h0398, 16'h039E, 16'h00C6, 16'h00E6, 16'h00DF,
        16'h00C9, 16'h00A4, 16'h00A1, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC,
        16'h00A7, 16'h00BF, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0};

    localparam logic [CODE_W-1:0] MAIN_GSM [MAIN_N] = '{
        7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08,
        7'h09, 7'h0B, 7'h0C, 7'h0E, 7'h0F, 7'h10, 7'h11, 7'h12, 7'h13,
        7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1A, 7'h1C, 7'h1D,
        7'h1E, 7'h1F, 7'h24, 7'h40, 7'h5B, 7'h5C, 7'h5D, 7'h5E, 7'h5F,
        7'h60, 7'h7B, 7'h7C, 7'h7D, 7'h7E, 7'h7F};

    localparam logic [CHAR_W-1:0] ESC_UNI [ESC_N] = '{
        16'h005E, 16'h007B, 16'h007D, 16'h005C, 16'h005B, 16'h007E,
        16'h005D, 16'h007C, 16'h20AC};

    localparam logic [CODE_W-1:0] ESC_GSM [ESC_N] = '{
        7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, 7'h65};

    typedef logic [2:0][BYTE_W-1:0] pend_t;

    typedef struct packed {
        logic              zero;
        logic              wait_more;
        logic [CHAR_W-1:0] ch;
        logic [1:0]        used;
    } dec_res_t;

    typedef struct packed {
        logic [1:0]        ncodes;
        logic [CODE_W-1:0] code0;
        logic [CODE_W-1:0] code1;
    } map_res_t;

endpackage

// ===== sv/utf8g7_dec.sv =====
// Lenient UTF-8 decoder over the pending byte window.
module utf8g7_dec
    import utf8g7_pkg::*;
(
    input  pend_t      pend,
    input  logic [1:0] cnt,
    input  logic       fin,
    output dec_res_t   res
);

    logic [BYTE_W-1:0] b0, b1, b2;
    logic [CHAR_W-1:0] single;

    assign b0 = pend[0];
    assign b1 = pend[1];
    assign b2 = pend[2];
    assign single = {9'd0, b0[6:0]};

    always_comb begin
        res           = '0;
        res.zero      = (b0 == '0);
        res.ch        = single;
        res.used      = 2'd1;
        if (b0 >= LEAD2_MIN && b0 < LEAD3_MIN) begin
            if (cnt < 2'd2) begin
                res.wait_more = !fin;
            end else if (b1 >= CONT_MIN) begin
                res.ch   = {5'd0, b0[4:0], b1[5:0]};
                res.used = 2'd2;
            end
        end else if (b0 >= LEAD3_MIN) begin
            if (cnt >= 2'd2 && b1 < CONT_MIN) begin
                res.ch = single;
            end else if (cnt < 2'd3) begin
                res.wait_more = !fin;
            end else if (b2 >= CONT_MIN) begin
                res.ch   = {b0[3:0], b1[5:0], b2[5:0]};
                res.used = 2'd3;
            end
        end
    end

endmodule

// ===== sv/utf8g7_map.sv =====
// Character to GSM 7-bit code mapper: main table, escape table, ASCII pass-through.
module utf8g7_map
    import utf8g7_pkg::*;
(
    input  logic [CHAR_W-1:0] ch,
    output map_res_t          res
);

    logic              hit_main, hit_esc, hit_ascii;
    logic [CODE_W-1:0] main_code, esc_code;

    always_comb begin
        hit_main  = 1'b0;
        hit_esc   = 1'b0;
        main_code = '0;
        esc_code  = '0;
        for (int i = 0; i < MAIN_N; i++) begin
            if (MAIN_UNI[i] == ch) begin
                hit_main  = 1'b1;
                main_code = main_code | MAIN_GSM[i];
            end
        end
        for (int i = 0; i < ESC_N; i++) begin
            if (ESC_UNI[i] == ch) begin
                hit_esc  = 1'b1;
                esc_code = esc_code | ESC_GSM[i];
            end
        end
        hit_ascii = (ch >= 16'h20 && ch <= 16'h23) || (ch >= 16'h25 && ch <= 16'h3F) ||
                    (ch >= 16'h41 && ch <= 16'h5A) || (ch >= 16'h61 && ch <= 16'h7A) ||
                    ch == 16'h0A || ch == 16'h0D;

        res = '0;
        if (hit_main) begin
            res.ncodes = 2'd1;
            res.code0  = main_code;
        end else if (hit_esc) begin
            res.ncodes = 2'd2;
            res.code0  = ESC_CODE;
            res.code1  = esc_code;
        end else if (hit_ascii) begin
            res.ncodes = 2'd1;
            res.code0  = ch[CODE_W-1:0];
        end
    end

endmodule

// ===== sv/utf8_to_gsm7_encoder.sv =====
// Top level: byte stream in, GSM 7-bit codes and a per-string status out.
// A byte is accepted in the idle state; the decode state then takes one character at a time
// (the escape state sends the second code of an escaped character) until it finds the window
// empty or waiting, and on the final byte the status state sends the string status. One byte
// can release up to three escaped characters.
// Result-side stalls hold the sequencer; ready only in the idle state. aresetn is
// synchronous, active low; it clears all control and string state.
module utf8_to_gsm7_encoder
    import utf8g7_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] utf8_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] gsm_code, [7] failed, [17:8] code_count
    output logic        m_tuser,   // is_status
    output logic        m_tlast    // last_result
);

    typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_ESC, ST_STATUS} state_t;

    state_t              state_reg, state_next;
    pend_t               pend_reg, pend_next, pend_shift;
    logic [1:0]          cnt_reg, cnt_next;
    logic                fin_reg, fin_next;
    logic                ended_reg, ended_next;
    logic                sticky_reg, sticky_next;
    logic [COUNT_W-1:0]  codes_reg, codes_next;
    logic [CODE_W-1:0]   esc_reg, esc_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;
    logic [CODE_W-1:0]   m_code_reg, m_code_next;
    logic                m_failed_reg, m_failed_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    dec_res_t            dec;
    map_res_t            map;
    logic                out_free;
    logic                over;
    logic [COUNT_W:0]    codes_sum;

    utf8g7_dec u_dec (
        .pend (pend_reg),
        .cnt  (cnt_reg),
        .fin  (fin_reg),
        .res  (dec)
    );

    utf8g7_map u_map (
        .ch  (dec.ch),
        .res (map)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign codes_sum = {1'b0, codes_reg} + {{(COUNT_W-1){1'b0}}, map.ncodes};
    assign over      = codes_sum > (COUNT_W+1)'(CODE_LIMIT);

    always_comb begin
        unique case (dec.used)
            2'd1:    pend_shift = {BYTE_W'(0), pend_reg[2], pend_reg[1]};
            2'd2:    pend_shift = {BYTE_W'(0), BYTE_W'(0), pend_reg[2]};
            default: pend_shift = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        fin_next      = fin_reg;
        ended_next    = ended_reg;
        sticky_next   = sticky_reg;
        codes_next    = codes_reg;
        esc_next      = esc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        m_code_next   = m_code_reg;
        m_failed_next = m_failed_reg;
        m_count_next  = m_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fin_next = s_tlast;
                    if (!ended_reg && cnt_reg < 2'd3) begin
                        pend_next[cnt_reg] = s_tdata;
                        cnt_next           = cnt_reg + 2'd1;
                    end
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (ended_reg || cnt_reg == 2'd0) begin
                    state_next = fin_reg ? ST_STATUS : ST_IDLE;
                end else if (dec.zero) begin
                    ended_next = 1'b1;
                    cnt_next   = 2'd0;
                    pend_next  = '0;
                end else if (dec.wait_more) begin
                    state_next = ST_IDLE;
                end else if (map.ncodes == 2'd0 || over) begin
                    sticky_next = 1'b1;
                    pend_next   = pend_shift;
                    cnt_next    = cnt_reg - dec.used;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b0;
                    m_code_next   = map.code0;
                    m_failed_next = 1'b0;
                    m_count_next  = '0;
                    pend_next     = pend_shift;
                    cnt_next      = cnt_reg - dec.used;
                    codes_next    = codes_sum[COUNT_W-1:0];
                    if (map.ncodes == 2'd2) begin
                        esc_next   = map.code1;
                        state_next = ST_ESC;
                    end
                end
            end
            ST_ESC: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b0;
                    m_code_next   = esc_reg;
                    m_failed_next = 1'b0;
                    m_count_next  = '0;
                    state_next    = ST_DECODE;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_code_next   = '0;
                    m_failed_next = sticky_reg || codes_reg == '0;
                    m_count_next  = codes_reg;
                    pend_next     = '0;
                    cnt_next      = 2'd0;
                    fin_next      = 1'b0;
                    ended_next    = 1'b0;
                    sticky_next   = 1'b0;
                    codes_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            cnt_reg      <= 2'd0;
            fin_reg      <= 1'b0;
            ended_reg    <= 1'b0;
            sticky_reg   <= 1'b0;
            codes_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            fin_reg      <= fin_next;
            ended_reg    <= ended_next;
            sticky_reg   <= sticky_next;
            codes_reg    <= codes_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        esc_reg      <= esc_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
        m_code_reg   <= m_code_next;
        m_failed_reg <= m_failed_next;
        m_count_reg  <= m_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {6'd0, m_count_reg, m_failed_reg, m_code_reg};

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status request without last flag");

    a_code_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        codes_reg <= COUNT_W'(CODE_LIMIT))
        else $error("emitted code count passed the limit");

    a_idle_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> cnt_reg != 2'd3)
        else $error("idle with a full pending window");

    a_code_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_count_reg == '0 && !m_failed_reg && !m_tlast)
        else $error("code request carries status fields");

endmodule

// ===== dv/utf8_to_gsm7_checker.sv =====
// Stream monitor for the UTF-8 to GSM 7-bit encoder: predicts and checks every result.
`timescale 1ns / 1ps

module utf8_to_gsm7_checker
    import utf8g7_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          gsm_pending
);

    typedef struct {
        logic              is_status;
        logic [CODE_W-1:0] gsm_code;
        logic              failed;
        logic [COUNT_W-1:0] code_count;
        logic              last_result;
    } gsm_res_t;

    gsm_res_t    gsm_expected[$];

    logic [7:0]  held_bytes [3];
    int unsigned held_n;
    bit          text_done;
    bit          bad_text;
    int unsigned codes_out;

    function automatic int gsm_lookup(input logic [CHAR_W-1:0] ch,
                                      output logic [CODE_W-1:0] c0,
                                      output logic [CODE_W-1:0] c1);
        c0 = '0;
        c1 = '0;
        for (int i = 0; i < MAIN_N; i++) begin
            if (MAIN_UNI[i] == ch) begin
                c0 = MAIN_GSM[i];
                return 1;
            end
        end
        for (int i = 0; i < ESC_N; i++) begin
            if (ESC_UNI[i] == ch) begin
                c0 = ESC_CODE;
                c1 = ESC_GSM[i];
                return 2;
            end
        end
        if ((ch >= 16'h20 && ch <= 16'h23) || (ch >= 16'h25 && ch <= 16'h3F) ||
            (ch >= 16'h41 && ch <= 16'h5A) || (ch >= 16'h61 && ch <= 16'h7A) ||
            ch == 16'h0A || ch == 16'h0D) begin
            c0 = ch[CODE_W-1:0];
            return 1;
        end
        return 0;
    endfunction

    task push_gsm(input logic st, input logic [CODE_W-1:0] code, input logic fl,
                  input logic [COUNT_W-1:0] cnt, input logic lst);
        gsm_res_t r;
        r.is_status   = st;
        r.gsm_code    = code;
        r.failed      = fl;
        r.code_count  = cnt;
        r.last_result = lst;
        gsm_expected.push_back(r);
    endtask

    task clear_text();
        held_bytes = '{default: '0};
        held_n     = 0;
        text_done  = 0;
        bad_text   = 0;
        codes_out  = 0;
    endtask

    task put_char(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] c0;
        logic [CODE_W-1:0] c1;
        int n;
        n = gsm_lookup(ch, c0, c1);
        if (n == 0 || codes_out + n > CODE_LIMIT) begin
            bad_text = 1;
        end else begin
            push_gsm(1'b0, c0, 1'b0, '0, 1'b0);
            if (n == 2)
                push_gsm(1'b0, c1, 1'b0, '0, 1'b0);
            codes_out += n;
        end
    endtask

    task drop_held(input int unsigned n);
        if (n > held_n)
            n = held_n;
        for (int i = 0; i < 3; i++)
            held_bytes[i] = (i + n < 3) ? held_bytes[i + n] : 8'h00;
        held_n -= n;
    endtask

    task predict_byte(input logic [7:0] b, input logic eot);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        bit         stall;
        if (!text_done && held_n < 3) begin
            held_bytes[held_n] = b;
            held_n++;
        end
        stall = 0;
        while (!text_done && held_n > 0 && !stall) begin
            b0 = held_bytes[0];
            b1 = held_bytes[1];
            b2 = held_bytes[2];
            if (b0 == 8'h00) begin
                text_done = 1;
                drop_held(held_n);
            end else if (b0 < CONT_MIN) begin
                put_char({9'b0, b0[6:0]});
                drop_held(1);
            end else if (b0 >= LEAD2_MIN && b0 < LEAD3_MIN) begin
                if (held_n < 2) begin
                    if (!eot) begin
                        stall = 1;
                    end else begin
                        put_char({9'b0, b0[6:0]});
                        drop_held(1);
                    end
                end else if (b1 >= CONT_MIN) begin
                    put_char({5'b0, b0[4:0], b1[5:0]});
                    drop_held(2);
                end else begin
                    put_char({9'b0, b0[6:0]});
                    drop_held(1);
                end
            end else if (b0 >= LEAD3_MIN) begin
                if (held_n >= 2 && b1 < CONT_MIN) begin
                    put_char({9'b0, b0[6:0]});
                    drop_held(1);
                end else if (held_n < 3) begin
                    if (!eot) begin
                        stall = 1;
                    end else begin
                        put_char({9'b0, b0[6:0]});
                        drop_held(1);
                    end
                end else if (b2 >= CONT_MIN) begin
                    put_char({b0[3:0], b1[5:0], b2[5:0]});
                    drop_held(3);
                end else begin
                    put_char({9'b0, b0[6:0]});
                    drop_held(1);
                end
            end else begin
                // stray continuation byte taken as a lead
                put_char({9'b0, b0[6:0]});
                drop_held(1);
            end
        end
        if (eot) begin
            push_gsm(1'b1, '0, bad_text || codes_out == 0, codes_out[COUNT_W-1:0], 1'b1);
            clear_text();
        end
    endtask

    always @(posedge aclk) begin
        gsm_res_t want;
        if (!aresetn) begin
            gsm_expected.delete();
            clear_text();
        end else begin
            if (m_tvalid && m_tready) begin
                if (gsm_expected.size() == 0) begin
                    $error("unexpected result: tdata %0h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = gsm_expected.pop_front();
                    if (m_tuser !== want.is_status) begin
                        $error("is_status: expected %0h, got %0h", want.is_status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[6:0] !== want.gsm_code) begin
                        $error("gsm_code: expected %0h, got %0h", want.gsm_code, m_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_tdata[7] !== want.failed) begin
                        $error("failed: expected %0h, got %0h", want.failed, m_tdata[7]);
                        fail_count++;
                    end
                    if (m_tdata[17:8] !== want.code_count) begin
                        $error("code_count: expected %0d, got %0d",
                               want.code_count, m_tdata[17:8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last_result) begin
                        $error("last_result: expected %0h, got %0h",
                               want.last_result, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
        end
        gsm_pending = gsm_expected.size();
    end

endmodule

// ===== dv/tb_utf8_to_gsm7_encoder.sv =====
// Testbench top for the UTF-8 to GSM 7-bit encoder: clock, reset, byte stimulus, verdict.
`timescale 1ns / 1ps

module tb_utf8_to_gsm7_encoder
    import utf8g7_pkg::*;
();

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 64;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] utf8_byte
    logic        s_tlast;   // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [6:0] gsm_code, [7] failed, [17:8] code_count
    logic        m_tuser;   // is_status
    logic        m_tlast;   // last_result

    int          chk_fails;
    int          chk_pending;

    logic [7:0]  text_bytes[$];
    int          burst_left;
    int          random_sent;
    int          idle_cycles  = 0;
    int          rx_hold_req  = 0;
    int          rx_hold_done = 0;
    int          rx_hold_cnt  = 0;
    rx_mode_t    rx_mode      = RX_OPEN;
    int          rx_mode_left = 0;
    int unsigned rx_tick      = 0;

    utf8_to_gsm7_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_to_gsm7_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (chk_fails),
        .gsm_pending (chk_pending)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // receiver: stall modes are picked at random and held for a random span; long hold on request
    always @(negedge aclk) begin
        rx_tick++;
        if (rx_hold_done != rx_hold_req) begin
            m_tready <= 1'b0;
            rx_hold_cnt++;
            if (rx_hold_cnt >= HOLD_CYCLES) begin
                rx_hold_done = rx_hold_req;
                rx_hold_cnt  = 0;
            end
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 80);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("utf8_to_gsm7_encoder regression: fail");
                $finish;
            end
        end
    end

    task send_request(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_request(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    task add_char(input logic [CHAR_W-1:0] ch);
        if (ch < 16'h80) begin
            text_bytes.push_back(ch[7:0]);
        end else if (ch < 16'h800) begin
            text_bytes.push_back({3'b110, ch[10:6]});
            text_bytes.push_back({2'b10, ch[5:0]});
        end else begin
            text_bytes.push_back({4'b1110, ch[15:12]});
            text_bytes.push_back({2'b10, ch[11:6]});
            text_bytes.push_back({2'b10, ch[5:0]});
        end
    endtask

    // mostly well-formed characters, some noise and broken sequences
    task build_random_text();
        int n_chars;
        int pick;
        n_chars = $urandom_range(1, 10);
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_char(CHAR_W'($urandom_range(16'h20, 16'h7E)));
            else if (pick < 60)
                add_char(MAIN_UNI[$urandom_range(0, MAIN_N - 1)]);
            else if (pick < 72)
                add_char(ESC_UNI[$urandom_range(0, ESC_N - 1)]);
            else if (pick < 76)
                add_char($urandom_range(0, 1) ? 16'h0A : 16'h0D);
            else if (pick < 80)
                add_char(CHAR_W'($urandom_range(16'h80, 16'hFFFF)));
            else if (pick < 88) begin
                text_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                text_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
            end else if (pick < 97)
                text_bytes.push_back(8'($urandom_range(8'h01, 8'hFF)));
            else
                text_bytes.push_back(8'h00);
        end
    endtask

    task wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        burst_left   = 0;
        random_sent  = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed strings
        text_bytes = '{8'h41};                      send_text();
        text_bytes = '{8'h00};                      send_text();  // empty text
        text_bytes = '{8'h7F};                      send_text();  // no GSM code
        text_bytes = '{8'h5E, 8'h40, 8'h24, 8'h0A, 8'h0D}; send_text();
        text_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC}; send_text();
        text_bytes = '{8'hC3, 8'h41};               send_text();  // lead without continuation
        text_bytes = '{8'hE2, 8'h82, 8'h41};        send_text();
        text_bytes = '{8'hE2, 8'h82};               send_text();  // cut off by end of text
        text_bytes = '{8'h41, 8'h00, 8'h42};        send_text();  // zero byte ends the text
        text_bytes = '{8'hFF, 8'h80, 8'hBF};        send_text();
        wait_drained();

        while (random_sent < RANDOM_BYTES / 2) begin
            build_random_text();
            random_sent += text_bytes.size();
            send_text();
        end

        // receiver holds off while a run of escaped characters goes in
        rx_hold_req++;
        repeat (20) text_bytes.push_back(8'h5E);
        text_bytes.push_back(8'h41);
        send_text();
        wait_drained();

        while (random_sent < RANDOM_BYTES) begin
            build_random_text();
            random_sent += text_bytes.size();
            send_text();
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (chk_fails == 0)
            $display("utf8_to_gsm7_encoder regression: pass");
        else
            $display("utf8_to_gsm7_encoder regression: fail");
        $finish;
    end

endmodule
